// File: rtl/core/dnia_pkg.sv
package dnia_pkg;

    localparam int UID_W   = 64;
    localparam int LEN_W   = 5;
    localparam int NODE_W  = 7;
    localparam int MS_W    = 16;
    localparam int CLK_W   = 32;
    localparam int OFF_W   = 5;
    localparam int BYTES_W = 48;
    localparam int CNT_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int REQ_BYTES = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_UID_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UID_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREF_ID   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOWUP  = 3'd4;

    localparam logic [NODE_W-1:0] PREF_ID_RESET  = 7'd73;
    localparam logic [MS_W-1:0]   PERIOD_RESET   = 16'd600;
    localparam logic [MS_W-1:0]   FOLLOWUP_RESET = 16'd400;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MSG  = 1'b1;

    typedef struct packed {
        logic              op;
        logic              msg_from_anonymous;
        logic [LEN_W-1:0]  msg_uid_len;
        logic [UID_W-1:0]  msg_uid_low;
        logic [UID_W-1:0]  msg_uid_high;
        logic [NODE_W-1:0] msg_node_id;
        logic [MS_W-1:0]   random_value;
    } t_req;

    typedef struct packed {
        logic               request_valid;
        logic [7:0]         request_head;
        logic [BYTES_W-1:0] request_uid_bytes;
        logic [CNT_W-1:0]   request_uid_count;
        logic               allocated;
        logic [NODE_W-1:0]  node_id;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
    } t_dp_cmd;

endpackage

// File: rtl/core/dnia_req_if.sv
interface dnia_req_if;
    import dnia_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic              msg_from_anonymous;
    logic [LEN_W-1:0]  msg_uid_len;
    logic [UID_W-1:0]  msg_uid_low;
    logic [UID_W-1:0]  msg_uid_high;
    logic [NODE_W-1:0] msg_node_id;
    logic [MS_W-1:0]   random_value;

    modport source (
        output valid, op, msg_from_anonymous, msg_uid_len, msg_uid_low, msg_uid_high,
               msg_node_id, random_value,
        input  ready
    );
    modport sink (
        input  valid, op, msg_from_anonymous, msg_uid_len, msg_uid_low, msg_uid_high,
               msg_node_id, random_value,
        output ready
    );
endinterface

// File: rtl/core/dnia_rsp_if.sv
interface dnia_rsp_if;
    import dnia_pkg::*;

    logic               valid;
    logic               ready;
    logic               request_valid;
    logic [7:0]         request_head;
    logic [BYTES_W-1:0] request_uid_bytes;
    logic [CNT_W-1:0]   request_uid_count;
    logic               allocated;
    logic [NODE_W-1:0]  node_id;

    modport source (
        output valid, request_valid, request_head, request_uid_bytes, request_uid_count,
               allocated, node_id,
        input  ready
    );
    modport sink (
        input  valid, request_valid, request_head, request_uid_bytes, request_uid_count,
               allocated, node_id,
        output ready
    );
endinterface

// File: rtl/core/dynamic_node_id_allocation_client_top.sv
// Anonymous dynamic node ID allocation client. Each request is a tick (one millisecond)
// or a received allocation message, and yields exactly one result carrying any
// allocation request to send plus the current allocation status. A request is accepted in
// the idle state, then the divide state forms the bit-serial remainder of the random
// sample by the follow-up limit, and the done state commits. The result is registered at
// the commit and the next request is taken in the cycle after the commit, even
// while the previous result waits in the output register; a result left waiting
// stalls the following request at its commit.
module dynamic_node_id_allocation_client_top #(
    parameter int UID_BYTES           = 16,
    parameter int MAX_UID_PER_REQUEST = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dnia_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dnia_pkg::UID_W-1:0]     i_cfg_data,
    dnia_req_if.sink                       i_req,
    dnia_rsp_if.source                     o_rsp
);
    import dnia_pkg::*;

    t_dp_cmd cmd;
    t_req    req;
    t_rsp    rsp;
    logic    in_ready;
    logic    out_valid;

    assign req.op                 = i_req.op;
    assign req.msg_from_anonymous = i_req.msg_from_anonymous;
    assign req.msg_uid_len        = i_req.msg_uid_len;
    assign req.msg_uid_low        = i_req.msg_uid_low;
    assign req.msg_uid_high       = i_req.msg_uid_high;
    assign req.msg_node_id        = i_req.msg_node_id;
    assign req.random_value       = i_req.random_value;
    assign i_req.ready            = in_ready;

    dnia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    dnia_dp #(
        .UID_BYTES           (UID_BYTES),
        .MAX_UID_PER_REQUEST (MAX_UID_PER_REQUEST)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .i_req      (req),
        .o_rsp      (rsp)
    );

    assign o_rsp.valid             = out_valid;
    assign o_rsp.request_valid     = rsp.request_valid;
    assign o_rsp.request_head      = rsp.request_head;
    assign o_rsp.request_uid_bytes = rsp.request_uid_bytes;
    assign o_rsp.request_uid_count = rsp.request_uid_count;
    assign o_rsp.allocated         = rsp.allocated;
    assign o_rsp.node_id           = rsp.node_id;

endmodule

// File: rtl/core/dnia_ctrl.sv
module dnia_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dnia_pkg::t_dp_cmd o_cmd
);
    import dnia_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/dnia_dp.sv
module dnia_dp #(
    parameter int UID_BYTES           = 16,
    parameter int MAX_UID_PER_REQUEST = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dnia_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dnia_pkg::UID_W-1:0]         i_cfg_data,
    input  dnia_pkg::t_dp_cmd                  i_cmd,
    input  dnia_pkg::t_req                     i_req,
    output dnia_pkg::t_rsp                     o_rsp
);
    import dnia_pkg::*;

    localparam logic [OFF_W-1:0] C_UB  = OFF_W'(UID_BYTES);
    localparam logic [CNT_W-1:0] C_MAX = CNT_W'(MAX_UID_PER_REQUEST);

    logic [UID_W-1:0]  r_uid_low, r_uid_high;
    logic [NODE_W-1:0] r_pref;
    logic [MS_W-1:0]   r_period, r_fdm;

    logic [CLK_W-1:0]  r_clock, r_deadline, r_base;
    logic [OFF_W-1:0]  r_offset;
    logic [NODE_W-1:0] r_assigned;

    t_req              r_req;
    logic [MS_W-1:0]   r_rem, r_dvd;
    t_rsp              r_rsp;

    logic [MS_W:0]        div_trial;
    logic [MS_W:0]        div_diff;
    logic [MS_W-1:0]      extra;
    logic [CLK_W-1:0]     rearm_dl, pull_dl;
    logic                 due;
    logic [OFF_W-1:0]     len_c;
    logic [15:0]          byte_ok;
    logic                 match;
    logic [127:0]         own_all, msg_all, own_shift;
    logic [OFF_W:0]       avail;
    logic [CNT_W-1:0]     n_bytes;
    logic [BYTES_W-1:0]   req_bytes;
    logic [CLK_W-1:0]     n_deadline;
    logic [OFF_W-1:0]     n_offset;
    logic [NODE_W-1:0]    n_assigned;
    t_rsp                 n_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uid_low  <= '0;
            r_uid_high <= '0;
            r_pref     <= PREF_ID_RESET;
            r_period   <= PERIOD_RESET;
            r_fdm      <= FOLLOWUP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UID_LOW:  r_uid_low  <= i_cfg_data;
                CFG_UID_HIGH: r_uid_high <= i_cfg_data;
                CFG_PREF_ID:  r_pref     <= i_cfg_data[NODE_W-1:0];
                CFG_PERIOD:   r_period   <= i_cfg_data[MS_W-1:0];
                CFG_FOLLOWUP: r_fdm      <= i_cfg_data[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign div_trial = {r_rem, r_dvd[MS_W-1]};
    assign div_diff  = div_trial - {1'b0, r_fdm};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_rem <= '0;
            r_dvd <= i_req.random_value;
        end else if (i_cmd.div_step) begin
            r_rem  <= div_diff[MS_W] ? div_trial[MS_W-1:0] : div_diff[MS_W-1:0];
            r_dvd  <= {r_dvd[MS_W-2:0], 1'b0};
            r_base <= r_clock + CLK_W'(r_period);
        end
    end

    assign extra    = (r_fdm == '0) ? '0 : r_rem;
    assign rearm_dl = r_base + CLK_W'(extra);
    assign pull_dl  = r_clock + CLK_W'(extra);
    assign due      = (r_assigned == '0) && (r_clock > r_deadline);

    assign own_all = {r_uid_high, r_uid_low};
    assign msg_all = {r_req.msg_uid_high, r_req.msg_uid_low};
    assign len_c   = (r_req.msg_uid_len > C_UB) ? C_UB : r_req.msg_uid_len;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            byte_ok[i] = (OFF_W'(i) >= len_c) ||
                         (msg_all[8*i +: 8] == ((i < UID_BYTES) ? own_all[8*i +: 8] : 8'd0));
        end
    end
    assign match = &byte_ok;

    assign own_shift = own_all >> {r_offset, 3'b000};
    assign avail     = {1'b0, C_UB} - {1'b0, r_offset};

    always_comb begin
        if (r_offset >= C_UB) begin
            n_bytes = '0;
        end else if (avail > (OFF_W+1)'(C_MAX)) begin
            n_bytes = C_MAX;
        end else begin
            n_bytes = avail[CNT_W-1:0];
        end
        for (int i = 0; i < REQ_BYTES; i++) begin
            req_bytes[8*i +: 8] = (CNT_W'(i) < n_bytes) ? own_shift[8*i +: 8] : 8'd0;
        end
    end

    always_comb begin
        n_deadline = r_deadline;
        n_offset   = r_offset;
        n_assigned = r_assigned;
        n_rsp      = '0;
        if (r_req.op == OP_TICK) begin
            if (due) begin
                n_deadline              = rearm_dl;
                n_rsp.request_valid     = 1'b1;
                n_rsp.request_head      = {r_pref, (r_offset == '0)};
                n_rsp.request_uid_bytes = req_bytes;
                n_rsp.request_uid_count = n_bytes;
            end
        end else if (r_assigned == '0) begin
            n_deadline = rearm_dl;
            if (r_req.msg_from_anonymous || !match) begin
                n_offset = '0;
            end else if (len_c < C_UB) begin
                n_offset   = len_c;
                n_deadline = pull_dl;
            end else begin
                n_assigned = r_req.msg_node_id;
            end
        end
        n_rsp.allocated = (n_assigned != '0);
        n_rsp.node_id   = n_assigned;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock    <= '0;
            r_deadline <= '0;
            r_offset   <= '0;
            r_assigned <= '0;
        end else if (i_cmd.load) begin
            if (i_req.op == OP_TICK) begin
                r_clock <= r_clock + CLK_W'(1);
            end
        end else if (i_cmd.commit) begin
            r_deadline <= n_deadline;
            r_offset   <= n_offset;
            r_assigned <= n_assigned;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule
